// ===== hdl/enf_pkg.sv =====
// ============================================================================
// enf_pkg: shared types and constants of the Euler normal flux block
// Fixed-point word and full-product types, and the saturation limits.
// ============================================================================
package enf_pkg;

	// Data word width of every fixed-point value in the datapath.
	localparam int DW = 32;

	typedef logic signed [DW-1:0]   fx_t;
	typedef logic signed [2*DW-1:0] prod_t;

	localparam fx_t FX_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {(DW-1){1'b0}}};

	// Reset value of 1/(gamma-1): 2.5 in Q16.16.
	localparam logic [30:0] IGM_RESET = 31'd163840;

endpackage

// ===== hdl/enf_delay.sv =====
// ============================================================================
// enf_delay: fixed-length register delay line
// Carries a word through DEPTH registers down the pipeline to meet later operands.
// ============================================================================
module enf_delay #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] stage_s [DEPTH];

	always_ff @(posedge clk) begin
		stage_s[0] <= d;
		for (int i = 1; i < DEPTH; i++) begin
			stage_s[i] <= stage_s[i-1];
		end
	end

	assign q = stage_s[DEPTH-1];

endmodule

// ===== hdl/enf_mul.sv =====
// ============================================================================
// enf_mul: two-stage rounding, saturating fixed-point multiplier
// Stage one registers the full signed product; stage two rounds to nearest
// with ties away from zero, drops the fraction bits and saturates.
// ============================================================================
module enf_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  enf_pkg::fx_t   a,
	input  enf_pkg::fx_t   b,
	output enf_pkg::fx_t   p
);

	localparam int PW = 2 * enf_pkg::DW;
	localparam enf_pkg::prod_t RND = enf_pkg::prod_t'(1) <<< (FRAC_BITS - 1);

	enf_pkg::prod_t prod_s1;
	enf_pkg::prod_t adj;
	enf_pkg::prod_t shifted;
	enf_pkg::fx_t   res_s2;
	logic           fits;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// A negative product rounds its magnitude away from zero, which on the
	// two's complement value is adding half an LSB minus one before the
	// arithmetic shift.
	always_comb begin
		adj     = prod_s1[PW-1] ? (prod_s1 + RND - enf_pkg::prod_t'(1)) : (prod_s1 + RND);
		shifted = adj >>> FRAC_BITS;
		fits    = (&shifted[PW-1:enf_pkg::DW-1]) || !(|shifted[PW-1:enf_pkg::DW-1]);
	end

	always_ff @(posedge clk) begin
		if (fits) begin
			res_s2 <= shifted[enf_pkg::DW-1:0];
		end else if (shifted[PW-1]) begin
			res_s2 <= enf_pkg::FX_MIN;
		end else begin
			res_s2 <= enf_pkg::FX_MAX;
		end
	end

	assign p = res_s2;

endmodule

// ===== hdl/enf_sadd.sv =====
// ============================================================================
// enf_sadd: registered saturating adder
// Adds two fixed-point words with one guard bit and clamps on overflow.
// ============================================================================
module enf_sadd (
	input  logic         clk,
	input  enf_pkg::fx_t a,
	input  enf_pkg::fx_t b,
	output enf_pkg::fx_t s
);

	logic signed [enf_pkg::DW:0] sum;
	enf_pkg::fx_t                sum_s1;

	assign sum = {a[enf_pkg::DW-1], a} + {b[enf_pkg::DW-1], b};

	always_ff @(posedge clk) begin
		if (sum[enf_pkg::DW] == sum[enf_pkg::DW-1]) begin
			sum_s1 <= sum[enf_pkg::DW-1:0];
		end else if (sum[enf_pkg::DW]) begin
			sum_s1 <= enf_pkg::FX_MIN;
		end else begin
			sum_s1 <= enf_pkg::FX_MAX;
		end
	end

	assign s = sum_s1;

endmodule

// ===== hdl/euler_normal_flux.sv =====
// ============================================================================
// euler_normal_flux: physical Euler flux of a gas state through one face
// Fully pipelined Q16.16 datapath computing mass, momentum and energy flux.
// ============================================================================
//
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ------------------------------------
// command   in         start, busy          density, velocity_*, pressure, normal_*
// result    out        done (strobe)        mass_flux, momentum_*_flux, energy_flux
// config    in         cfg_valid, cfg_ready cfg_data (1/(gamma-1), Q16.16)
//
// The block takes one command transfer in every clock cycle; busy is never
// raised, since nothing inside the pipeline can stall.
// The latency from command to result is set by the energy path: four registered
// multiply levels (the velocity terms, density times the squared speed, the
// factor one half and the final product with vn) and the four registered
// saturating adds between them.
// Results are shown for one cycle with done high; the receiver cannot stall.
// Reset (arst_n low) clears the valid bits and returns the register to 2.5.
// Configuration is always ready and takes effect for commands after the write.
//
// Every product rounds to nearest with ties away from zero and saturates to
// the signed word range, and every sum saturates. The velocity and speed sums
// run left to right with each partial sum saturated, so they are built from
// chained two-input adders rather than one three-input adder.
//
module euler_normal_flux #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        start,
	output logic        busy,
	input  logic [30:0] density,
	input  logic [31:0] velocity_x,
	input  logic [31:0] velocity_y,
	input  logic [31:0] velocity_z,
	input  logic [30:0] pressure,
	input  logic [31:0] normal_x,
	input  logic [31:0] normal_y,
	input  logic [31:0] normal_z,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data,

	output logic        done,
	output logic [31:0] mass_flux,
	output logic [31:0] momentum_x_flux,
	output logic [31:0] momentum_y_flux,
	output logic [31:0] momentum_z_flux,
	output logic [31:0] energy_flux
);

	// Total pipeline latency from command transfer to result strobe.
	localparam int LAT = 12;
	localparam enf_pkg::fx_t HALF = enf_pkg::fx_t'(1) <<< (FRAC_BITS - 1);

	logic [30:0]       igm_q;
	logic [LAT-1:0]    valid_s;

	enf_pkg::fx_t rho, u, v, w, pr, nx, ny, nz, gm;

	// Products of the first multiply level.
	enf_pkg::fx_t unx, vny, wnz, uu, vv, ww, rhou, rhov, rhow, pnx, pny, pnz, pgm;
	enf_pkg::fx_t wnz_d, ww_d, rho_d4, rhou_d, rhov_d, rhow_d;
	enf_pkg::fx_t pnx_d, pny_d, pnz_d, pgm_d, pr_d;

	// Sums and the later product levels.
	enf_pkg::fx_t vn01, vn, sp01, speed2;
	enf_pkg::fx_t rho_sp, rhou_vn, rhov_vn, rhow_vn, mass;
	enf_pkg::fx_t mom_x, mom_y, mom_z, kin, energy, e_plus_p, vn_d, eflux;
	enf_pkg::fx_t mass_d, mom_x_d, mom_y_d, mom_z_d;

	// --------------------------------------------------------------------
	// Handshakes and the configuration register.
	// --------------------------------------------------------------------
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			igm_q <= enf_pkg::IGM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			igm_q <= cfg_data;
		end
	end

	// The valid bit rides alongside the data through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[LAT-2:0], start && !busy};
		end
	end

	assign done = valid_s[LAT-1];

	// Unsigned fields are widened with a zero sign bit.
	assign rho = {1'b0, density};
	assign pr  = {1'b0, pressure};
	assign gm  = {1'b0, igm_q};
	assign u   = velocity_x;
	assign v   = velocity_y;
	assign w   = velocity_z;
	assign nx  = normal_x;
	assign ny  = normal_y;
	assign nz  = normal_z;

	// --------------------------------------------------------------------
	// First multiply level: all products of raw inputs.
	// --------------------------------------------------------------------
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_unx  (.clk(clk), .a(u),   .b(nx), .p(unx));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vny  (.clk(clk), .a(v),   .b(ny), .p(vny));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_wnz  (.clk(clk), .a(w),   .b(nz), .p(wnz));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_uu   (.clk(clk), .a(u),   .b(u),  .p(uu));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vv   (.clk(clk), .a(v),   .b(v),  .p(vv));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_ww   (.clk(clk), .a(w),   .b(w),  .p(ww));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_rhou (.clk(clk), .a(rho), .b(u),  .p(rhou));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_rhov (.clk(clk), .a(rho), .b(v),  .p(rhov));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_rhow (.clk(clk), .a(rho), .b(w),  .p(rhow));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_pnx  (.clk(clk), .a(pr),  .b(nx), .p(pnx));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_pny  (.clk(clk), .a(pr),  .b(ny), .p(pny));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_pnz  (.clk(clk), .a(pr),  .b(nz), .p(pnz));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_pgm  (.clk(clk), .a(pr),  .b(gm), .p(pgm));

	// --------------------------------------------------------------------
	// Normal velocity and squared speed, summed left to right.
	// --------------------------------------------------------------------
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(1)) u_d_wnz (.clk(clk), .d(wnz), .q(wnz_d));
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(1)) u_d_ww  (.clk(clk), .d(ww),  .q(ww_d));

	enf_sadd u_a_vn01 (.clk(clk), .a(unx),  .b(vny),   .s(vn01));
	enf_sadd u_a_vn   (.clk(clk), .a(vn01), .b(wnz_d), .s(vn));
	enf_sadd u_a_sp01 (.clk(clk), .a(uu),   .b(vv),    .s(sp01));
	enf_sadd u_a_sp   (.clk(clk), .a(sp01), .b(ww_d),  .s(speed2));

	// --------------------------------------------------------------------
	// Second multiply level: the products with vn and density times the squared speed.
	// --------------------------------------------------------------------
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(4)) u_d_rho  (.clk(clk), .d(rho),  .q(rho_d4));
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(2)) u_d_rhou (.clk(clk), .d(rhou), .q(rhou_d));
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(2)) u_d_rhov (.clk(clk), .d(rhov), .q(rhov_d));
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(2)) u_d_rhow (.clk(clk), .d(rhow), .q(rhow_d));

	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_rsp  (.clk(clk), .a(rho_d4), .b(speed2), .p(rho_sp));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_mass (.clk(clk), .a(rho_d4), .b(vn),     .p(mass));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_ruvn (.clk(clk), .a(rhou_d), .b(vn),     .p(rhou_vn));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_rvvn (.clk(clk), .a(rhov_d), .b(vn),     .p(rhov_vn));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_rwvn (.clk(clk), .a(rhow_d), .b(vn),     .p(rhow_vn));

	// --------------------------------------------------------------------
	// Momentum fluxes: add the pressure term along the normal.
	// --------------------------------------------------------------------
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(4)) u_d_pnx (.clk(clk), .d(pnx), .q(pnx_d));
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(4)) u_d_pny (.clk(clk), .d(pny), .q(pny_d));
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(4)) u_d_pnz (.clk(clk), .d(pnz), .q(pnz_d));

	enf_sadd u_a_momx (.clk(clk), .a(rhou_vn), .b(pnx_d), .s(mom_x));
	enf_sadd u_a_momy (.clk(clk), .a(rhov_vn), .b(pny_d), .s(mom_y));
	enf_sadd u_a_momz (.clk(clk), .a(rhow_vn), .b(pnz_d), .s(mom_z));

	// --------------------------------------------------------------------
	// Energy path: kinetic term, total energy, plus pressure,
	// then times vn. The factor one half goes through an ordinary multiply
	// so that it rounds exactly like every other product.
	// --------------------------------------------------------------------
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(6)) u_d_pgm (.clk(clk), .d(pgm), .q(pgm_d));
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(9)) u_d_pr  (.clk(clk), .d(pr),  .q(pr_d));
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(6)) u_d_vn  (.clk(clk), .d(vn),  .q(vn_d));

	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_kin (.clk(clk), .a(HALF), .b(rho_sp), .p(kin));
	enf_sadd u_a_en  (.clk(clk), .a(pgm_d),  .b(kin),  .s(energy));
	enf_sadd u_a_ep  (.clk(clk), .a(energy), .b(pr_d), .s(e_plus_p));
	enf_mul #(.FRAC_BITS(FRAC_BITS)) u_m_ef  (.clk(clk), .a(e_plus_p), .b(vn_d), .p(eflux));

	// --------------------------------------------------------------------
	// Align the early results with the energy flux at the output.
	// --------------------------------------------------------------------
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(6)) u_d_mass (.clk(clk), .d(mass),  .q(mass_d));
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(5)) u_d_momx (.clk(clk), .d(mom_x), .q(mom_x_d));
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(5)) u_d_momy (.clk(clk), .d(mom_y), .q(mom_y_d));
	enf_delay #(.WIDTH(enf_pkg::DW), .DEPTH(5)) u_d_momz (.clk(clk), .d(mom_z), .q(mom_z_d));

	assign mass_flux       = mass_d;
	assign momentum_x_flux = mom_x_d;
	assign momentum_y_flux = mom_y_d;
	assign momentum_z_flux = mom_z_d;
	assign energy_flux     = eflux;

`ifndef NO_ASSERTIONS
	// Every strobe belongs to a command taken exactly the pipeline latency earlier.
	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching command");

	// Every command produces its strobe exactly the pipeline latency later.
	a_cmd_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("command did not produce a result");

	// Zero density gives zero mass flux for that item.
	a_zero_mass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(density == 31'd0, LAT)) |-> (mass_flux == 32'd0))
		else $error("mass flux not zero for zero density");

	// Vacuum (no density, no pressure) carries neither momentum nor energy; x momentum and energy are checked.
	a_vacuum: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(density == 31'd0 && pressure == 31'd0, LAT)) |->
		(momentum_x_flux == 32'd0 && energy_flux == 32'd0))
		else $error("nonzero flux for a vacuum state");
`endif

endmodule
